>>> rtl/sus_pkg.sv
`default_nettype none

package sus_pkg;

	// request kinds
	localparam logic [1:0] REQ_INSERT   = 2'd0;
	localparam logic [1:0] REQ_ERASE    = 2'd1;
	localparam logic [1:0] REQ_CONTAINS = 2'd2;
	localparam logic [1:0] REQ_GET      = 2'd3;

	typedef struct packed {
		logic [1:0]  req_type;
		logic [31:0] key;
		logic [5:0]  position;
	} sus_req_t;

	typedef struct packed {
		logic        success;
		logic [31:0] key_out;
		logic [6:0]  element_count;
		logic        table_full;
	} sus_rsp_t;

	// read address source
	typedef enum logic [1:0] {
		RD_IDX,
		RD_IDX_M1,
		RD_IDX_P1,
		RD_POS
	} sus_rd_sel_t;

	// controller -> datapath
	typedef struct packed {
		logic        load;
		logic        idx_inc;
		logic        idx_dec;
		logic        idx_from_cnt;
		logic        idx_from_rank;
		logic        mark;
		logic        mark_hit;
		logic        rd_en;
		sus_rd_sel_t rd_sel;
		logic        wr_key;
		logic        wr_move;
		logic        cnt_inc;
		logic        cnt_dec;
		logic        respond;
		logic        rsp_ok;
		logic        rsp_full;
		logic        rsp_key;
	} sus_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] req_type;
		logic       scan_end;
		logic       key_ge;
		logic       key_eq;
		logic       present;
		logic       is_full;
		logic       at_rank;
		logic       dn_end;
		logic       pos_oob;
	} sus_sts_t;

endpackage

`default_nettype wire

>>> rtl/sus_datapath.sv
`default_nettype none

module sus_datapath #(
	parameter int CAPACITY  = 64,
	parameter int KEY_WIDTH = 32
) (
	input  wire              clk,
	input  wire              arst_n,
	input  sus_pkg::sus_req_t req,
	input  sus_pkg::sus_cmd_t cmd,
	output sus_pkg::sus_sts_t sts,
	output logic             done,
	output sus_pkg::sus_rsp_t rsp
);
	import sus_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);
	localparam int AW = $clog2(CAPACITY);
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	logic [KEY_WIDTH-1:0] mem [CAPACITY];
	logic [KEY_WIDTH-1:0] rd_data_q;

	logic [1:0]           req_type_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [5:0]           pos_q;
	logic [CW-1:0]        idx_q;
	logic [CW-1:0]        rank_q;
	logic [CW-1:0]        cnt_q;
	logic                 present_q;

	logic [KEY_WIDTH+31:0] key_ext;
	logic [KEY_WIDTH+31:0] kout_ext;
	logic [CW+5:0]         pos_w;
	logic [CW+5:0]         cnt_w;
	logic [CW+5:0]         pos_ext;
	logic [CW:0]           idx_p1_w;
	logic [CW-1:0]         rd_ptr;
	logic [CW-1:0]         cnt_nxt;
	logic [CW+6:0]         cnt_out_ext;

	assign key_ext  = {32'd0, req.key};
	assign kout_ext = {32'd0, rd_data_q};
	assign pos_w    = {{CW{1'b0}}, pos_q};
	assign cnt_w    = {6'd0, cnt_q};
	assign pos_ext  = {{CW{1'b0}}, pos_q};
	assign idx_p1_w = {1'b0, idx_q} + {{CW{1'b0}}, 1'b1};

	always_comb begin
		unique case (cmd.rd_sel)
			RD_IDX:    rd_ptr = idx_q;
			RD_IDX_M1: rd_ptr = idx_q - CW'(1);
			RD_IDX_P1: rd_ptr = idx_p1_w[CW-1:0];
			RD_POS:    rd_ptr = pos_ext[CW-1:0];
			default:   rd_ptr = idx_q;
		endcase
	end

	always_comb begin
		cnt_nxt = cnt_q;
		if (cmd.cnt_inc) begin
			cnt_nxt = cnt_q + CW'(1);
		end else if (cmd.cnt_dec) begin
			cnt_nxt = cnt_q - CW'(1);
		end
	end
	assign cnt_out_ext = {7'd0, cnt_nxt};

	assign sts.req_type = req_type_q;
	assign sts.scan_end = (idx_q >= cnt_q);
	assign sts.key_ge   = (rd_data_q >= key_q);
	assign sts.key_eq   = (rd_data_q == key_q);
	assign sts.present  = present_q;
	assign sts.is_full  = (cnt_q == CAP_C);
	assign sts.at_rank  = (idx_q == rank_q);
	assign sts.dn_end   = (idx_p1_w >= {1'b0, cnt_q});
	assign sts.pos_oob  = (pos_w >= cnt_w);

	// key store: one write, one registered read
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_data_q <= mem[rd_ptr[AW-1:0]];
		end
		if (cmd.wr_key) begin
			mem[rank_q[AW-1:0]] <= key_q;
		end else if (cmd.wr_move) begin
			mem[idx_q[AW-1:0]] <= rd_data_q;
		end
	end

	// request word, plus the rank and hit marked by the search
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_type_q <= req.req_type;
			key_q      <= key_ext[KEY_WIDTH-1:0];
			pos_q      <= req.position;
		end
		if (cmd.mark) begin
			rank_q    <= idx_q;
			present_q <= cmd.mark_hit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			cnt_q <= '0;
		end else begin
			cnt_q <= cnt_nxt;
			if (cmd.load) begin
				idx_q <= '0;
			end else if (cmd.idx_from_cnt) begin
				idx_q <= cnt_q;
			end else if (cmd.idx_from_rank) begin
				idx_q <= rank_q;
			end else if (cmd.idx_inc) begin
				idx_q <= idx_p1_w[CW-1:0];
			end else if (cmd.idx_dec) begin
				idx_q <= idx_q - CW'(1);
			end
		end
	end

	// result word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= cmd.respond;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.respond) begin
			rsp.success       <= cmd.rsp_ok;
			rsp.key_out       <= cmd.rsp_key ? kout_ext[31:0] : 32'd0;
			rsp.element_count <= cnt_out_ext[6:0];
			rsp.table_full    <= cmd.rsp_full;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CAP_C)
		else $error("held count above capacity");

	a_no_grow_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.cnt_inc |-> (cnt_q != CAP_C))
		else $error("insert grew a full table");

	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |-> $past(cmd.respond))
		else $error("count moved outside a response");

endmodule

`default_nettype wire

>>> rtl/sus_ctrl.sv
`default_nettype none

module sus_ctrl (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	output logic             busy,
	input  sus_pkg::sus_sts_t sts,
	output sus_pkg::sus_cmd_t cmd
);
	import sus_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE,
		S_SCAN_RD,
		S_SCAN_CMP,
		S_DECIDE,
		S_UP_RD,
		S_UP_WR,
		S_DN_RD,
		S_DN_WR,
		S_GET_RD,
		S_GET_DONE
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.load = 1'b1;
					state_d  = S_SCAN_RD;
				end
			end
			S_SCAN_RD: begin
				if (sts.req_type == REQ_GET) begin
					state_d = S_GET_RD;
				end else if (sts.scan_end) begin
					// ran off the end: rank is the count, key absent
					cmd.mark = 1'b1;
					state_d  = S_DECIDE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_IDX;
					state_d    = S_SCAN_CMP;
				end
			end
			S_SCAN_CMP: begin
				if (sts.key_ge) begin
					cmd.mark     = 1'b1;
					cmd.mark_hit = sts.key_eq;
					state_d      = S_DECIDE;
				end else begin
					cmd.idx_inc = 1'b1;
					state_d     = S_SCAN_RD;
				end
			end
			S_DECIDE: begin
				unique case (sts.req_type)
					REQ_INSERT: begin
						if (sts.present) begin
							cmd.respond = 1'b1;
							state_d     = S_IDLE;
						end else if (sts.is_full) begin
							cmd.respond  = 1'b1;
							cmd.rsp_full = 1'b1;
							state_d      = S_IDLE;
						end else begin
							cmd.idx_from_cnt = 1'b1;
							state_d          = S_UP_RD;
						end
					end
					REQ_ERASE: begin
						if (sts.present) begin
							cmd.idx_from_rank = 1'b1;
							state_d           = S_DN_RD;
						end else begin
							cmd.respond = 1'b1;
							state_d     = S_IDLE;
						end
					end
					default: begin
						cmd.respond = 1'b1;
						cmd.rsp_ok  = sts.present;
						state_d     = S_IDLE;
					end
				endcase
			end
			S_UP_RD: begin
				if (sts.at_rank) begin
					cmd.wr_key  = 1'b1;
					cmd.cnt_inc = 1'b1;
					cmd.respond = 1'b1;
					cmd.rsp_ok  = 1'b1;
					state_d     = S_IDLE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_IDX_M1;
					state_d    = S_UP_WR;
				end
			end
			S_UP_WR: begin
				cmd.wr_move = 1'b1;
				cmd.idx_dec = 1'b1;
				state_d     = S_UP_RD;
			end
			S_DN_RD: begin
				if (sts.dn_end) begin
					cmd.cnt_dec = 1'b1;
					cmd.respond = 1'b1;
					cmd.rsp_ok  = 1'b1;
					state_d     = S_IDLE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_IDX_P1;
					state_d    = S_DN_WR;
				end
			end
			S_DN_WR: begin
				cmd.wr_move = 1'b1;
				cmd.idx_inc = 1'b1;
				state_d     = S_DN_RD;
			end
			S_GET_RD: begin
				if (sts.pos_oob) begin
					cmd.respond = 1'b1;
					state_d     = S_IDLE;
				end else begin
					cmd.rd_en  = 1'b1;
					cmd.rd_sel = RD_POS;
					state_d    = S_GET_DONE;
				end
			end
			S_GET_DONE: begin
				cmd.respond = 1'b1;
				cmd.rsp_ok  = 1'b1;
				cmd.rsp_key = 1'b1;
				state_d     = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			busy    <= 1'b0;
		end else begin
			state_q <= state_d;
			busy    <= (state_d != S_IDLE);
		end
	end

endmodule

`default_nettype wire

>>> rtl/sorted_unique_key_set_unit.sv
`default_nettype none

// Sequence: a linear search for the rank; contains, or a request that changes nothing, answers then;
// a stored insert shifts keys up from the count to the rank and writes the key; erase shifts keys down.
// Get by rank reads one RAM word, or answers without a read when the rank is out of range.
// Sequential: next word taken in the done cycle, one request at a time (one RAM port).
// done pulses one cycle with the result word; the receiver cannot stall it.
// Reset (arst_n low, async): count clears to zero and the unit goes idle; key RAM is not cleared.

module sorted_unique_key_set_unit #(
	parameter int CAPACITY  = 64,
	parameter int KEY_WIDTH = 32
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              start,
	output logic             busy,
	input  sus_pkg::sus_req_t req,
	output logic             done,
	output sus_pkg::sus_rsp_t rsp
);
	import sus_pkg::*;

	// command and status between sequencer and datapath
	sus_cmd_t cmd;
	sus_sts_t sts;

	// sequencer: linear rank search, then a shift walk through the RAM; get reads its rank directly
	sus_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sts    (sts),
		.cmd    (cmd)
	);

	// key RAM, index/count registers, comparators, result word register
	sus_datapath #(
		.CAPACITY  (CAPACITY),
		.KEY_WIDTH (KEY_WIDTH)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.cmd    (cmd),
		.sts    (sts),
		.done   (done),
		.rsp    (rsp)
	);

	// a result word leaves only when the unit has returned to idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result word while busy");

	// every result word closes a request that was in flight
	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result word without a request");

	// refused-when-full never reports success
	a_full_fail: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.table_full) |-> !rsp.success)
		else $error("full flag with success");

	// only a successful get carries a key
	a_key_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !rsp.success) |-> (rsp.key_out == 32'd0))
		else $error("key on a failed request");

endmodule

`default_nettype wire
